### hdl/fbc_pkg.sv
// ----------------------------------------------------------------------------
// fbc_pkg
// Shared types and constants for the frustum box cull block.
// ----------------------------------------------------------------------------
package fbc_pkg;

  localparam int KIND_W = 2;
  localparam int IDX_W  = 4;
  localparam int ELEM_W = 24;
  localparam int BOX_W  = 32;
  localparam int VERD_W = 2;
  localparam int FRAC_B = 16;

  localparam logic [KIND_W-1:0] KIND_PROJ = 2'd0;
  localparam logic [KIND_W-1:0] KIND_VIEW = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REBUILD = 2'd2;
  localparam logic [KIND_W-1:0] KIND_BOX = 2'd3;

  localparam logic [VERD_W-1:0] VERD_OUTSIDE = 2'd0;
  localparam logic [VERD_W-1:0] VERD_INTERSECT = 2'd1;
  localparam logic [VERD_W-1:0] VERD_INSIDE = 2'd2;

  // controller -> datapath commands
  typedef struct packed {
    logic       load;      // capture input beat
    logic       clip_en;   // accumulate one clip product
    logic [3:0] clip_e;    // clip element r*4+c
    logic [1:0] clip_k;
    logic       clip_clr;  // start new clip element
    logic       clip_wr;   // write finished clip element
    logic       plane_en;  // write one plane row from clip
    logic [1:0] plane_r;
    logic       box_clr;
    logic       box_mul;   // low coefficient half products for one plane
    logic       box_mulh;  // high coefficient half products for one plane
    logic       box_sum;   // sum stage for one plane
    logic [2:0] box_p;
  } fbc_cmd_t;

  typedef struct packed {
    logic [VERD_W-1:0] verdict;
  } fbc_sts_t;

endpackage

### hdl/fbc_if.sv
// ----------------------------------------------------------------------------
// fbc_in_if / fbc_out_if
// Valid/ready channels for box cull items and verdicts.
// ----------------------------------------------------------------------------
interface fbc_in_if;
  import fbc_pkg::*;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [IDX_W-1:0]  elem_index;
  logic signed [ELEM_W-1:0] elem_value;
  logic signed [BOX_W-1:0]  min_x, min_y, min_z, max_x, max_y, max_z;
  modport source (output valid, kind, elem_index, elem_value,
                  min_x, min_y, min_z, max_x, max_y, max_z, input ready);
  modport sink (input valid, kind, elem_index, elem_value,
                min_x, min_y, min_z, max_x, max_y, max_z, output ready);
endinterface

interface fbc_out_if;
  import fbc_pkg::*;
  logic              valid;
  logic              ready;
  logic [VERD_W-1:0] verdict;
  modport source (output valid, verdict, input ready);
  modport sink (input valid, verdict, output ready);
endinterface

### hdl/fbc_datapath.sv
// ----------------------------------------------------------------------------
// fbc_datapath
// Matrix store, clip multiply-accumulate, plane store and corner evaluator.
// ----------------------------------------------------------------------------
module fbc_datapath import fbc_pkg::*; #(
  parameter int MATRIX_WIDTH = 24,
  parameter int COORD_WIDTH  = 32
) (
  input  logic clk,
  input  logic rst_n,
  input  fbc_cmd_t cmd,
  output fbc_sts_t sts,
  input  logic [KIND_W-1:0] in_kind,
  input  logic [IDX_W-1:0]  in_elem_index,
  input  logic signed [ELEM_W-1:0] in_elem_value,
  input  logic signed [BOX_W-1:0]  in_min_x, in_min_y, in_min_z,
  input  logic signed [BOX_W-1:0]  in_max_x, in_max_y, in_max_z
);
  localparam int MW = MATRIX_WIDTH;
  localparam int CW = 2*MW + 2;          // clip element
  localparam int PW = 2*MW + 3;          // plane coefficient
  localparam int LB = (PW + 1) / 2;      // low coefficient half, unsigned
  localparam int HB = PW - LB;           // high coefficient half, signed
  localparam int TW = PW + COORD_WIDTH + 1; // one product
  localparam int SW = TW + 2;            // sum of four

  logic signed [MW-1:0] proj_r [16];
  logic signed [MW-1:0] view_r [16];
  logic signed [CW-1:0] clip_r [16];
  logic signed [PW-1:0] pl_r [24];
  logic signed [CW-1:0] acc_r;
  logic signed [2*MW-1:0] prod_r;
  logic [3:0] clip_wa_r;
  logic signed [COORD_WIDTH-1:0] lo_r [3];
  logic signed [COORD_WIDTH-1:0] hi_r [3];
  logic signed [TW-1:0] tlo_r [3];
  logic signed [TW-1:0] thi_r [3];
  logic signed [TW-1:0] td_r;
  logic zero_r, any_behind_r, outside_r;
  logic [7:0] behind;
  logic [2:0] pb;

  function automatic logic signed [LB+COORD_WIDTH:0] mul_lo(
    input logic [LB-1:0] c, input logic signed [COORD_WIDTH-1:0] x);
    return $signed({1'b0, c}) * x;
  endfunction

  function automatic logic signed [HB+COORD_WIDTH-1:0] mul_hi(
    input logic signed [HB-1:0] c, input logic signed [COORD_WIDTH-1:0] x);
    return c * x;
  endfunction

  assign pb = cmd.box_p;

  always_comb begin
    for (int n = 0; n < 8; n++) begin
      logic signed [SW-1:0] s;
      s = SW'(n[0] ? thi_r[0] : tlo_r[0]) + SW'(n[1] ? thi_r[1] : tlo_r[1])
        + SW'(n[2] ? thi_r[2] : tlo_r[2]) + SW'(td_r);
      behind[n] = zero_r | s[SW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lo_r[0] <= in_min_x[COORD_WIDTH-1:0];
      lo_r[1] <= in_min_y[COORD_WIDTH-1:0];
      lo_r[2] <= in_min_z[COORD_WIDTH-1:0];
      hi_r[0] <= in_max_x[COORD_WIDTH-1:0];
      hi_r[1] <= in_max_y[COORD_WIDTH-1:0];
      hi_r[2] <= in_max_z[COORD_WIDTH-1:0];
    end
    // clip: stage 1 multiply, stage 2 accumulate
    prod_r <= view_r[{cmd.clip_e[3:2], cmd.clip_k}] * proj_r[{cmd.clip_k, cmd.clip_e[1:0]}];
    clip_wa_r <= cmd.clip_e;
    if (cmd.clip_en) begin
      if (cmd.clip_clr) acc_r <= CW'(prod_r);
      else acc_r <= acc_r + CW'(prod_r);
    end
    if (cmd.clip_wr) clip_r[clip_wa_r] <= acc_r + CW'(prod_r);
    // corner terms: coefficient split in two halves, products shared by corners
    if (cmd.box_mul) begin
      for (int i = 0; i < 3; i++) begin
        tlo_r[i] <= TW'(mul_lo(pl_r[{pb, 2'(i)}][LB-1:0], lo_r[i]));
        thi_r[i] <= TW'(mul_lo(pl_r[{pb, 2'(i)}][LB-1:0], hi_r[i]));
      end
      td_r <= TW'(pl_r[{pb, 2'd3}]) <<< FRAC_B;
      zero_r <= (pl_r[{pb,2'd0}] == '0) && (pl_r[{pb,2'd1}] == '0) && (pl_r[{pb,2'd2}] == '0);
    end else if (cmd.box_mulh) begin
      for (int i = 0; i < 3; i++) begin
        tlo_r[i] <= tlo_r[i] + (TW'(mul_hi(pl_r[{pb, 2'(i)}][PW-1:LB], lo_r[i])) <<< LB);
        thi_r[i] <= thi_r[i] + (TW'(mul_hi(pl_r[{pb, 2'(i)}][PW-1:LB], hi_r[i])) <<< LB);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) begin
        proj_r[i] <= '0;
        view_r[i] <= '0;
      end
      for (int i = 0; i < 24; i++) pl_r[i] <= '0;
      any_behind_r <= 1'b0;
      outside_r <= 1'b0;
    end else begin
      if (cmd.load && in_kind == KIND_PROJ) proj_r[in_elem_index] <= in_elem_value[MW-1:0];
      if (cmd.load && in_kind == KIND_VIEW) view_r[in_elem_index] <= in_elem_value[MW-1:0];
      if (cmd.plane_en) begin
        for (int p = 0; p < 6; p++) begin
          logic signed [PW-1:0] b, t;
          b = PW'(clip_r[{cmd.plane_r, 2'd3}]);
          t = PW'(clip_r[{cmd.plane_r, 2'(p >> 1)}]);
          pl_r[p*4 + int'(cmd.plane_r)] <= (p == 0 || p == 3 || p == 4) ? b - t : b + t;
        end
      end
      if (cmd.box_clr) begin
        any_behind_r <= 1'b0;
        outside_r <= 1'b0;
      end else if (cmd.box_sum) begin
        if (|behind) any_behind_r <= 1'b1;
        if (&behind) outside_r <= 1'b1;
      end
    end
  end

  assign sts.verdict = outside_r ? VERD_OUTSIDE :
                       any_behind_r ? VERD_INTERSECT : VERD_INSIDE;
endmodule

### hdl/fbc_ctrl.sv
// ----------------------------------------------------------------------------
// fbc_ctrl
// Sequencer: accepts beats, steps rebuild and box passes, holds the verdict.
// ----------------------------------------------------------------------------
module fbc_ctrl import fbc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic [KIND_W-1:0] in_kind,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output logic [VERD_W-1:0] out_verdict,
  output fbc_cmd_t cmd,
  input  fbc_sts_t sts
);
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CLIP  = 5'b00010,
    S_PLANE = 5'b00100,
    S_BOX   = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic [5:0] cnt_r, cnt_nxt;   // rebuild: {e,k}; box: {plane, phase}
  logic ov_r, ov_nxt;
  logic [VERD_W-1:0] verd_r;
  logic take;
  logic [5:0] lag_r;            // multiply step whose product sits in prod_r
  logic lag_v_r;

  assign in_ready = (state_r == S_IDLE) && !ov_r;
  assign take = in_valid && in_ready;
  assign out_valid = ov_r;
  assign out_verdict = verd_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    ov_nxt = ov_r && !out_ready;
    cmd = '0;
    cmd.load = take;
    cmd.clip_e = cnt_r[5:2];
    cmd.clip_k = cnt_r[1:0];
    cmd.plane_r = cnt_r[1:0];
    cmd.box_p = cnt_r[4:2];
    // clip accumulation runs one register (lag_r) behind the multiply address
    cmd.clip_en = lag_v_r;
    cmd.clip_clr = lag_v_r && lag_r[1:0] == 2'd0;
    cmd.clip_wr = lag_v_r && lag_r[1:0] == 2'd3;
    case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
        cmd.box_clr = 1'b1;
        if (take && in_kind == KIND_REBUILD) state_nxt = S_CLIP;
        if (take && in_kind == KIND_BOX) state_nxt = S_BOX;
      end
      S_CLIP: begin
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd63) state_nxt = S_PLANE;
      end
      S_PLANE: begin
        cmd.plane_en = 1'b1;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r[1:0] == 2'd3) state_nxt = S_IDLE;
      end
      S_BOX: begin
        // phase 0: low half products, 1: high half products, 2: corner signs
        cmd.box_mul = cnt_r[1:0] == 2'd0;
        cmd.box_mulh = cnt_r[1:0] == 2'd1;
        cmd.box_sum = cnt_r[1:0] == 2'd2;
        if (cnt_r[1:0] == 2'd2) begin
          cnt_nxt = {cnt_r[5:2] + 4'd1, 2'd0};
          if (cnt_r[4:2] == 3'd5) state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r + 6'd1;
        end
      end
      S_DONE: begin
        ov_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      ov_r <= 1'b0;
      lag_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      ov_r <= ov_nxt;
      lag_v_r <= (state_r == S_CLIP);
    end
  end

  always_ff @(posedge clk) begin
    lag_r <= cnt_r;
    if (state_r == S_DONE) verd_r <= sts.verdict;
  end
endmodule

### hdl/frustum_box_cull_core.sv
// ----------------------------------------------------------------------------
// frustum_box_cull_core
// View-frustum culling of axis-aligned boxes against a view*projection pair.
// ----------------------------------------------------------------------------
// Usage:
//   in  channel: one beat per item. kind 0/1 write a projection/view element,
//   kind 2 rebuilds the six planes, kind 3 tests a box.
//   out channel: one verdict beat per box test (0 outside, 1 intersecting,
//   2 inside). Other kinds give no beat.
// Sequence:
//   element write: the next beat may follow right away.
//   Rebuild: 64 clip multiply steps plus 4 plane rows; no new beat is taken
//   until the plane rows are written.
//   Box test: six planes, each with a low-half and a high-half coefficient
//   multiply step (eight corners share the per-axis min/max products) and
//   one corner sign step; the verdict is held once all six planes are done.
//   No new beat is taken until the receiver has taken that verdict.
// Reset: matrices and planes clear to zero, so every box reads outside until
//   a rebuild. A stalled receiver holds the verdict and blocks new beats.
// ----------------------------------------------------------------------------
module frustum_box_cull_core import fbc_pkg::*; #(
  parameter int MATRIX_WIDTH = 24,
  parameter int COORD_WIDTH  = 32
) (
  input logic clk,
  input logic rst_n,
  fbc_in_if.sink   in_ch,
  fbc_out_if.source out_ch
);
  fbc_cmd_t cmd;
  fbc_sts_t sts;

  fbc_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_kind(in_ch.kind), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_verdict(out_ch.verdict),
    .cmd, .sts
  );

  fbc_datapath #(.MATRIX_WIDTH(MATRIX_WIDTH), .COORD_WIDTH(COORD_WIDTH)) u_dp (
    .clk, .rst_n, .cmd, .sts,
    .in_kind(in_ch.kind), .in_elem_index(in_ch.elem_index),
    .in_elem_value(in_ch.elem_value),
    .in_min_x(in_ch.min_x), .in_min_y(in_ch.min_y), .in_min_z(in_ch.min_z),
    .in_max_x(in_ch.max_x), .in_max_y(in_ch.max_y), .in_max_z(in_ch.max_z)
  );
endmodule

### sim/fbc_test_if.sv
// ----------------------------------------------------------------------------
// fbc_test_if
// Testbench-side channel interfaces come from the RTL; this file holds the
// beat record type the checker shares with the stimulus side.
// ----------------------------------------------------------------------------
package fbc_test_pkg;
  import fbc_pkg::*;

  typedef struct {
    logic [KIND_W-1:0]        kind;
    logic [IDX_W-1:0]         elem_index;
    logic signed [ELEM_W-1:0] elem_value;
    logic signed [BOX_W-1:0]  min_x, min_y, min_z, max_x, max_y, max_z;
  } cull_beat_t;
endpackage

### sim/frustum_box_cull_core_test.sv
// ----------------------------------------------------------------------------
// frustum_box_cull_core_test
// Drives matrix writes, plane rebuilds and box tests into the cull core,
// predicts each verdict with an exact 128-bit plane evaluation and checks
// every verdict beat in order under random stalls on both channels.
// ----------------------------------------------------------------------------
module frustum_box_cull_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import fbc_pkg::*;
  import fbc_test_pkg::*;

  localparam int WATCHDOG_CYCLES = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #6 clk = ~clk;

  fbc_in_if  in_ch ();
  fbc_out_if out_ch ();

  frustum_box_cull_core dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // Predictor state: matrices and plane coefficients, all exact.
  logic signed [63:0] proj_m [16];
  logic signed [63:0] view_m [16];
  logic signed [63:0] planes [24];

  logic [VERD_W-1:0] verdict_q [$];
  int errors = 0;
  int idle_cycles = 0;
  bit out_stall_long = 0;

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function automatic void clear_model();
    for (int i = 0; i < 16; i++) begin
      proj_m[i] = 0;
      view_m[i] = 0;
    end
    for (int i = 0; i < 24; i++) planes[i] = 0;
  endfunction

  function automatic void rebuild_frustum();
    logic signed [63:0] clip [16];
    logic signed [63:0] base, term;
    int sel;
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++) begin
        clip[r*4+c] = 0;
        for (int k = 0; k < 4; k++) clip[r*4+c] += view_m[r*4+k] * proj_m[k*4+c];
      end
    for (int p = 0; p < 6; p++)
      for (int r = 0; r < 4; r++) begin
        sel = p / 2;
        base = clip[r*4+3];
        term = clip[r*4+sel];
        // right, top, back subtract the selected column
        planes[p*4+r] = (p == 0 || p == 3 || p == 4) ? base - term : base + term;
      end
  endfunction

  function automatic logic [VERD_W-1:0] classify_box(input cull_beat_t b);
    logic signed [127:0] s;
    logic signed [63:0] x, y, z;
    bit any_behind, any_front, behind;
    any_behind = 0;
    for (int p = 0; p < 6; p++) begin
      any_front = 0;
      for (int n = 0; n < 8; n++) begin
        x = n[0] ? 64'(b.max_x) : 64'(b.min_x);
        y = n[1] ? 64'(b.max_y) : 64'(b.min_y);
        z = n[2] ? 64'(b.max_z) : 64'(b.min_z);
        s = 128'(planes[p*4]) * 128'(x) + 128'(planes[p*4+1]) * 128'(y)
          + 128'(planes[p*4+2]) * 128'(z) + (128'(planes[p*4+3]) <<< FRAC_B);
        // zero normal: everything is behind
        behind = (planes[p*4] == 0 && planes[p*4+1] == 0 && planes[p*4+2] == 0)
                 || s < 0;
        if (behind) any_behind = 1;
        else any_front = 1;
      end
      if (!any_front) return VERD_OUTSIDE;
    end
    return any_behind ? VERD_INTERSECT : VERD_INSIDE;
  endfunction

  function automatic void predict_beat(input cull_beat_t b);
    case (b.kind)
      KIND_PROJ:    proj_m[b.elem_index] = 64'(b.elem_value);
      KIND_VIEW:    view_m[b.elem_index] = 64'(b.elem_value);
      KIND_REBUILD: rebuild_frustum();
      default:      verdict_q.push_back(classify_box(b));
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Sender: one beat, with a random gap before it. Valid stays high across
  // back-to-back beats and drops only for a gap or a drain.
  task automatic send_beat(input cull_beat_t b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.kind       <= b.kind;
    in_ch.elem_index <= b.elem_index;
    in_ch.elem_value <= b.elem_value;
    in_ch.min_x <= b.min_x; in_ch.min_y <= b.min_y; in_ch.min_z <= b.min_z;
    in_ch.max_x <= b.max_x; in_ch.max_y <= b.max_y; in_ch.max_z <= b.max_z;
    do @(posedge clk); while (!in_ch.ready);
    predict_beat(b);
  endtask

  function automatic cull_beat_t blank_beat(input logic [KIND_W-1:0] k);
    cull_beat_t b;
    b.kind = k;
    b.elem_index = IDX_W'($urandom);
    b.elem_value = ELEM_W'($urandom);
    b.min_x = $urandom; b.min_y = $urandom; b.min_z = $urandom;
    b.max_x = $urandom; b.max_y = $urandom; b.max_z = $urandom;
    return b;
  endfunction

  task automatic write_elem(input logic [KIND_W-1:0] k, input int idx,
                            input logic signed [ELEM_W-1:0] v);
    cull_beat_t b;
    b = blank_beat(k);
    b.elem_index = IDX_W'(idx);
    b.elem_value = v;
    send_beat(b);
  endtask

  // Random box: mostly small coordinates near the frustum, some full-range.
  function automatic logic signed [BOX_W-1:0] rand_coord();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return BOX_W'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
  endfunction

  task automatic send_box(input logic signed [BOX_W-1:0] lx, ly, lz, hx, hy, hz);
    cull_beat_t b;
    b = blank_beat(KIND_BOX);
    b.min_x = lx; b.min_y = ly; b.min_z = lz;
    b.max_x = hx; b.max_y = hy; b.max_z = hz;
    send_beat(b);
  endtask

  task automatic send_rand_box();
    logic signed [BOX_W-1:0] a, c;
    cull_beat_t b;
    b = blank_beat(KIND_BOX);
    a = rand_coord(); c = rand_coord();
    b.min_x = a; b.max_x = ($urandom_range(0, 9) == 0) ? c : a + (c & 32'h3ffff);
    a = rand_coord(); c = rand_coord();
    b.min_y = a; b.max_y = ($urandom_range(0, 9) == 0) ? c : a + (c & 32'h3ffff);
    a = rand_coord(); c = rand_coord();
    b.min_z = a; b.max_z = ($urandom_range(0, 9) == 0) ? c : a + (c & 32'h3ffff);
    send_beat(b);
  endtask

  // Matrix element: mostly near-identity Q8.16 values, sometimes full range.
  function automatic logic signed [ELEM_W-1:0] rand_elem(input int idx);
    case ($urandom_range(0, 5))
      0:       return ELEM_W'($urandom);
      1:       return $urandom_range(0, 1) ? 24'sh7fffff : -24'sh800000;
      default: return ((idx % 5) == 0 ? 24'sh010000 : 24'sh0)
                      + ELEM_W'($signed($urandom_range(0, 16'h4000)) - 16'sh2000);
    endcase
  endfunction

  task automatic load_matrices(input bit identity);
    for (int i = 0; i < 16; i++) begin
      write_elem(KIND_PROJ, i, identity ? ((i % 5) == 0 ? 24'sh010000 : 24'sh0)
                                        : rand_elem(i));
      write_elem(KIND_VIEW, i, identity ? ((i % 5) == 0 ? 24'sh010000 : 24'sh0)
                                        : rand_elem(i));
    end
    send_beat(blank_beat(KIND_REBUILD));
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
  endtask

  // Reset planes are all zero-normal, so every box reads outside.
  task automatic test_after_reset();
    send_box(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
             32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
    send_box(0, 0, 0, 0, 0, 0);
  endtask

  // Identity clip: unit cube frustum; inside, straddling, outside, inverted.
  task automatic test_directed_boxes();
    load_matrices(1);
    send_box(-32'sh8000, -32'sh8000, -32'sh8000, 32'sh8000, 32'sh8000, 32'sh8000);
    send_box(-32'sh20000, -32'sh8000, -32'sh8000, 32'sh8000, 32'sh8000, 32'sh8000);
    send_box(32'sh30000, 0, 0, 32'sh40000, 32'sh8000, 32'sh8000);
    send_box(32'sh8000, 32'sh8000, 32'sh8000, -32'sh8000, -32'sh8000, -32'sh8000);
    send_box(32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000,
             32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff);
    // extreme matrix elements, then stale-plane check before rebuild
    write_elem(KIND_PROJ, 15, 24'sh7fffff);
    write_elem(KIND_VIEW, 0, -24'sh800000);
    send_box(0, 0, 0, 32'sh8000, 32'sh8000, 32'sh8000);
    send_beat(blank_beat(KIND_REBUILD));
    send_box(0, 0, 0, 32'sh8000, 32'sh8000, 32'sh8000);
  endtask

  // Mostly box tests with occasional element writes and rebuilds.
  task automatic test_random_mix(input int n_items);
    int r;
    for (int i = 0; i < n_items; i++) begin
      r = $urandom_range(0, 99);
      if (r < 8) write_elem(KIND_PROJ, $urandom_range(0, 15), rand_elem($urandom_range(0, 15)));
      else if (r < 16) write_elem(KIND_VIEW, $urandom_range(0, 15),
                                  rand_elem($urandom_range(0, 15)));
      else if (r < 20) send_beat(blank_beat(KIND_REBUILD));
      else send_rand_box();
      if (i % 300 == 150) load_matrices(i % 600 == 150);
    end
  endtask

  // Sender holds off until every verdict is back, then resumes.
  task automatic test_drain_pause();
    send_rand_box();
    send_rand_box();
    wait_drained();
    send_rand_box();
  endtask

  // Verdict checker and receiver stall generator.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (verdict_q.size() == 0) report($sformatf("unexpected verdict %0d", out_ch.verdict));
        else begin
          if (out_ch.verdict !== verdict_q[0])
            report($sformatf("verdict %0d, predicted %0d", out_ch.verdict, verdict_q[0]));
          void'(verdict_q.pop_front());
        end
      end
      if ($urandom_range(0, 199) == 0) out_stall_long <= ~out_stall_long;
      out_ch.ready <= out_stall_long ? ($urandom_range(0, 19) == 0)
                                     : ($urandom_range(0, 3) != 0);
    end
  end

  // Watchdog: cycles without any beat on either channel.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_PROJ;
    in_ch.elem_index = '0;
    in_ch.elem_value = '0;
    in_ch.min_x = '0; in_ch.min_y = '0; in_ch.min_z = '0;
    in_ch.max_x = '0; in_ch.max_y = '0; in_ch.max_z = '0;
    out_ch.ready = 1'b0;
    clear_model();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_after_reset();
    test_directed_boxes();
    test_drain_pause();
    test_random_mix(1050);
    wait_drained();
    repeat (40) @(posedge clk);
    if (errors == 0 && verdict_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

### frustum_box_cull_core.f
hdl/fbc_pkg.sv
hdl/fbc_if.sv
hdl/fbc_datapath.sv
hdl/fbc_ctrl.sv
hdl/frustum_box_cull_core.sv
sim/fbc_test_if.sv
sim/frustum_box_cull_core_test.sv
